>>> hw/rtl/kprq_pkg.sv
// kprq_pkg: sizes, status codes and request codes for the kth present remove queue.
// Used by kth_present_remove_queue; no dependencies.
`default_nettype none

package kprq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int LEVELS     = $clog2(CAPACITY);
   localparam int SLOT_W     = LEVELS;
   localparam int NODE_W     = LEVELS + 1;
   localparam int TREE_DEPTH = 2 * CAPACITY;
   localparam int COUNT_W    = LEVELS + 1;
   localparam int ID_W       = 31;
   localparam int POS_W      = 11;
   localparam int STATUS_W   = 2;
   localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   typedef enum logic [STATUS_W-1:0] {
      ST_REMOVED = 2'd0,
      ST_NONE    = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/kth_present_remove_queue.sv
// kth_present_remove_queue: ordered id store with append at tail and remove of the k-th live id.
// Count tree and id store are on-chip memories; depends on kprq_pkg.
//
//   channel  ports                                  direction
//   req      req_valid req_stall req_type
//            req_new_id req_position                in (stall out)
//   rsp      rsp_valid rsp_stall rsp_status
//            rsp_removed_id                         out (stall in)
//
// Append: read-modify-write of the count at each tree level, root to leaf (LEVELS+1 levels).
// Remove: count read and decrement per tree level, then id read and output load.
// Rejected words go straight to the output state. The single tree memory port pair sets the pace.
// After reset, a clearing pass writes zero to all 2*CAPACITY (2048) tree words; no word is taken.
// A finished word waits in the output register while rsp_stall is high.
`default_nettype none

module kth_present_remove_queue
   import kprq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_type,
   input  wire logic [ID_W-1:0]     req_new_id,
   input  wire logic [POS_W-1:0]    req_position,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_removed_id
);

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_APP_RD  = 9'b000000100,
      S_APP_WR  = 9'b000001000,
      S_REM_RD  = 9'b000010000,
      S_REM_CMP = 9'b000100000,
      S_ID_WAIT = 9'b001000000,
      S_OUT     = 9'b010000000,
      S_SPARE   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [COUNT_W-1:0]   cur_ff, cur_in;
   logic [CMP_W-1:0]     k_ff, k_in;
   logic [SLOT_W-1:0]    path_ff, path_in;
   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [SLOT_W:0]      next_slot_ff, next_slot_in;
   logic [COUNT_W-1:0]   live_total_ff, live_total_in;
   status_type           res_status_ff, res_status_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;

   logic [COUNT_W-1:0]   tree_mem [TREE_DEPTH];
   logic [COUNT_W-1:0]   tree_rd_ff;
   logic                 tree_we, tree_re;
   logic [NODE_W-1:0]    tree_waddr, tree_raddr;
   logic [COUNT_W-1:0]   tree_wdata;

   logic [ID_W-1:0]      slot_mem [CAPACITY];
   logic [ID_W-1:0]      slot_rd_ff;
   logic                 slot_we, slot_re;

   logic                 is_leaf;
   logic                 rsp_load;
   logic [CMP_W-1:0]     left_ext, pos_ext, live_ext;

   assign is_leaf   = node_ff[LEVELS];
   assign left_ext  = CMP_W'(tree_rd_ff);
   assign pos_ext   = CMP_W'(req_position);
   assign live_ext  = CMP_W'(live_total_ff);
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_removed_id = rsp_id_ff;

   always_comb begin
      state_in      = state_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      path_in       = path_ff;
      clr_in        = clr_ff;
      next_slot_in  = next_slot_ff;
      live_total_in = live_total_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      tree_we       = 1'b0;
      tree_re       = 1'b0;
      tree_waddr    = node_ff;
      tree_raddr    = node_ff;
      tree_wdata    = '0;
      slot_we       = 1'b0;
      slot_re       = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            tree_we    = 1'b1;
            tree_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_APPEND) begin
                  if (next_slot_ff == (SLOT_W+1)'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     res_id_in     = '0;
                     state_in      = S_OUT;
                  end else begin
                     slot_we       = 1'b1;
                     node_in       = NODE_W'(1);
                     path_in       = next_slot_ff[SLOT_W-1:0];
                     next_slot_in  = next_slot_ff + 1'b1;
                     live_total_in = live_total_ff + 1'b1;
                     state_in      = S_APP_RD;
                  end
               end else begin
                  if (pos_ext == '0 || pos_ext > live_ext) begin
                     res_status_in = ST_NONE;
                     res_id_in     = '0;
                     state_in      = S_OUT;
                  end else begin
                     node_in       = NODE_W'(1);
                     cur_in        = live_total_ff;
                     k_in          = pos_ext;
                     live_total_in = live_total_ff - 1'b1;
                     state_in      = S_REM_RD;
                  end
               end
            end
         end
         S_APP_RD: begin
            tree_re  = 1'b1;
            state_in = S_APP_WR;
         end
         S_APP_WR: begin
            tree_we    = 1'b1;
            tree_wdata = tree_rd_ff + 1'b1;
            if (is_leaf) begin
               state_in = S_IDLE;
            end else begin
               node_in  = {node_ff[NODE_W-2:0], path_ff[SLOT_W-1]};
               path_in  = path_ff << 1;
               state_in = S_APP_RD;
            end
         end
         S_REM_RD: begin
            tree_we    = 1'b1;
            tree_wdata = cur_ff - 1'b1;
            if (is_leaf) begin
               slot_re  = 1'b1;
               state_in = S_ID_WAIT;
            end else begin
               tree_re    = 1'b1;
               tree_raddr = {node_ff[NODE_W-2:0], 1'b0};
               state_in   = S_REM_CMP;
            end
         end
         S_REM_CMP: begin
            if (k_ff <= left_ext) begin
               node_in = {node_ff[NODE_W-2:0], 1'b0};
               cur_in  = tree_rd_ff;
            end else begin
               node_in = {node_ff[NODE_W-2:0], 1'b1};
               cur_in  = cur_ff - tree_rd_ff;
               k_in    = k_ff - left_ext;
            end
            state_in = S_REM_RD;
         end
         S_ID_WAIT: begin
            res_status_in = ST_REMOVED;
            res_id_in     = slot_rd_ff;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         next_slot_ff  <= '0;
         live_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         next_slot_ff  <= next_slot_in;
         live_total_ff <= live_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      path_ff       <= path_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_waddr] <= tree_wdata;
      end
      if (tree_re) begin
         tree_rd_ff <= tree_mem[tree_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[next_slot_ff[SLOT_W-1:0]] <= req_new_id;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[node_ff[SLOT_W-1:0]];
      end
   end

   a_rank_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM_CMP) |-> (k_ff != '0 && k_ff <= CMP_W'(cur_ff)))
      else $error("rank left the range of the current subtree");

   a_leaf_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM_RD && is_leaf) |-> (cur_ff == COUNT_W'(1)))
      else $error("descent reached a leaf whose live count is not one");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("output word loaded outside the output state");

   a_live_le_fill: assert property (@(posedge clock) disable iff (reset)
      (COUNT_W+1)'(live_total_ff) <= (COUNT_W+1)'(next_slot_ff))
      else $error("live count exceeds slots filled");

   a_fill_le_cap: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= (SLOT_W+1)'(CAPACITY))
      else $error("fill count beyond capacity");

endmodule

`default_nettype wire
